[rtl/core/quaternion_orientation_integrator_assert.svh]
// Assertion macros shared by the orientation integrator RTL.
// No dependencies; included by modules that carry concurrent checks.
`ifndef QUATERNION_ORIENTATION_INTEGRATOR_ASSERT_SVH
`define QUATERNION_ORIENTATION_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define QOI_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QOI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/qoi_pkg.sv]
// Shared types and constants for the quaternion orientation integrator.
// No dependencies; imported by every module of the block.
package qoi_pkg;

	localparam int MAG_W    = 64;
	localparam int MUL_W    = 32;
	localparam int PROD_W   = 64;
	localparam int ROOT_W   = 32;
	localparam int REM_W    = ROOT_W + 1;
	localparam int SCALE_LO = 30;

	// 1.0 with 33 fraction bits, scalar part of the integrate multiplier
	localparam logic [MAG_W-1:0] R0_INTEG = 64'h0000_0002_0000_0000;

	typedef enum logic [1:0] {
		ACT_INTEGRATE = 2'd0,
		ACT_ROTATE    = 2'd1,
		ACT_LOAD      = 2'd2,
		ACT_HOLD      = 2'd3
	} qoi_action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RMUL,
		ST_QSCALE,
		ST_RSCALE,
		ST_MUL,
		ST_ACC,
		ST_PSCALE,
		ST_SQUARE,
		ST_SUM,
		ST_ROOT,
		ST_DIV,
		ST_WRITE,
		ST_OUT
	} qoi_state_t;

	typedef struct packed {
		logic start;
		logic norm_top;
	} scale_ctl_t;

	typedef logic [3:0][MAG_W-1:0]  mag4_t;
	typedef logic [3:0][MUL_W-1:0]  op4_t;
	typedef logic [3:0][PROD_W-1:0] prod4_t;

	// Hamilton product: lane = output part, second index = term
	localparam logic [0:3][0:3][1:0] HM_A = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd3, 2'd1},
		'{2'd0, 2'd3, 2'd1, 2'd2}
	};
	localparam logic [0:3][0:3][1:0] HM_B = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd2, 2'd1}
	};
	localparam logic [0:3][0:3] HM_NEG = '{4'b0111, 4'b0001, 4'b0001, 4'b0001};

endpackage

[rtl/core/qoi_if.sv]
// Valid/ready channel interfaces for the orientation integrator.
// No dependencies; input word and result word channels.
interface qoi_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] vec_x;
	logic signed [31:0] vec_y;
	logic signed [31:0] vec_z;
	logic signed [31:0] load_w;
	logic [15:0]        time_step;

	modport source (output valid, action, vec_x, vec_y, vec_z, load_w, time_step,
		input ready);
	modport sink (input valid, action, vec_x, vec_y, vec_z, load_w, time_step,
		output ready);
endinterface

interface qoi_out_if #(parameter int COMPONENT_BITS = 32);
	logic                             valid;
	logic                             ready;
	logic signed [COMPONENT_BITS-1:0] out_w;
	logic signed [COMPONENT_BITS-1:0] out_x;
	logic signed [COMPONENT_BITS-1:0] out_y;
	logic signed [COMPONENT_BITS-1:0] out_z;
	logic                             zero_norm;

	modport source (output valid, out_w, out_x, out_y, out_z, zero_norm, input ready);
	modport sink (input valid, out_w, out_x, out_y, out_z, zero_norm, output ready);
endinterface

[rtl/core/qoi_scale.sv]
// Block scaler: four magnitudes shifted together one bit per cycle.
// Depends on qoi_pkg.
module qoi_scale import qoi_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  scale_ctl_t ctl,
	input  mag4_t      mag_in,
	output mag4_t      mag_out,
	output logic       done
);

	mag4_t mag_q;
	logic  top_q;
	logic  busy_q;
	logic  hi_any;
	logic  lo_none;
	logic  all_zero;
	logic  settle;

	always_comb begin
		hi_any   = 1'b0;
		lo_none  = 1'b1;
		all_zero = 1'b1;
		for (int i = 0; i < 4; i++) begin
			if (top_q) begin
				hi_any  = hi_any | (mag_q[i][MAG_W-1:SCALE_LO+1] != '0);
				lo_none = lo_none & (mag_q[i][MAG_W-1:SCALE_LO] == '0);
			end else begin
				hi_any  = hi_any | (mag_q[i][MAG_W-1:SCALE_LO] != '0);
				lo_none = lo_none & (mag_q[i][MAG_W-1:SCALE_LO-1] == '0);
			end
			all_zero = all_zero & (mag_q[i] == '0);
		end
		settle = !hi_any && !(lo_none && !all_zero);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			top_q  <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			top_q  <= ctl.norm_top;
		end else if (busy_q && settle) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			mag_q <= mag_in;
		end else if (busy_q) begin
			for (int i = 0; i < 4; i++) begin
				if (hi_any)
					mag_q[i] <= mag_q[i] >> 1;
				else if (lo_none && !all_zero)
					mag_q[i] <= mag_q[i] << 1;
			end
		end
	end

	assign mag_out = mag_q;
	assign done    = busy_q && settle;

endmodule

[rtl/core/qoi_mul.sv]
// Four-lane bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on qoi_pkg.
module qoi_mul import qoi_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   start,
	input  op4_t   a_in,
	input  op4_t   b_in,
	output prod4_t prod,
	output logic   done
);

	localparam int CNT_W = $clog2(MUL_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MUL_W - 1);

	op4_t             a_q;
	op4_t             b_q;
	prod4_t           prod_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	// multiplier consumed msb first
	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a_in;
			b_q    <= b_in;
			prod_q <= '0;
		end else if (busy_q) begin
			for (int i = 0; i < 4; i++) begin
				prod_q[i] <= {prod_q[i][PROD_W-2:0], 1'b0}
					+ (b_q[i][MUL_W-1] ? PROD_W'(a_q[i]) : '0);
				b_q[i] <= b_q[i] << 1;
			end
		end
	end

	assign prod = prod_q;
	assign done = done_q;

endmodule

[rtl/core/qoi_root.sv]
// Integer square root, two radicand bits per cycle.
// Depends on qoi_pkg.
module qoi_root import qoi_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] n_in,
	output logic [ROOT_W-1:0] root,
	output logic              done
);

	localparam logic [PROD_W-1:0] BIT_INIT = {2'b01, {(PROD_W-2){1'b0}}};

	logic [PROD_W-1:0] n_q;
	logic [PROD_W-1:0] res_q;
	logic [PROD_W-1:0] bit_q;
	logic [PROD_W-1:0] trial;
	logic              busy_q;
	logic              done_q;

	assign trial = res_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= n_in;
			res_q <= '0;
			bit_q <= BIT_INIT;
		end else if (busy_q) begin
			if (n_q >= trial) begin
				n_q   <= n_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[ROOT_W-1:0];
	assign done = done_q;

endmodule

[rtl/core/qoi_div.sv]
// Four-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on qoi_pkg.
module qoi_div import qoi_pkg::*; #(
	parameter int QUO_W = 31
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  op4_t                  a_in,
	input  logic [ROOT_W-1:0]     m_in,
	output logic [3:0][QUO_W-1:0] quo,
	output logic                  done
);

	localparam int CNT_W = $clog2(QUO_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(QUO_W - 1);

	logic [3:0][REM_W-1:0] r_q;
	logic [3:0][REM_W-1:0] trial;
	logic [3:0]            ge;
	logic [3:0][QUO_W-1:0] q_q;
	logic [ROOT_W-1:0]     m_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  first_q;
	logic                  busy_q;
	logic                  done_q;

	// first step compares the dividend unshifted (quotient bit of weight 1.0)
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			trial[i] = first_q ? r_q[i] : {r_q[i][REM_W-2:0], 1'b0};
			ge[i]    = trial[i] >= {1'b0, m_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			first_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CNT_LAST);
			if (start) begin
				busy_q  <= 1'b1;
				first_q <= 1'b1;
				cnt_q   <= '0;
			end else if (busy_q) begin
				first_q <= 1'b0;
				cnt_q   <= cnt_q + 1'b1;
				if (cnt_q == CNT_LAST)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			m_q <= m_in;
			for (int i = 0; i < 4; i++) begin
				r_q[i] <= {1'b0, a_in[i]};
				q_q[i] <= '0;
			end
		end else if (busy_q) begin
			for (int i = 0; i < 4; i++) begin
				r_q[i] <= ge[i] ? trial[i] - {1'b0, m_q} : trial[i];
				q_q[i] <= {q_q[i][QUO_W-2:0], ge[i]};
			end
		end
	end

	assign quo  = q_q;
	assign done = done_q;

endmodule

[rtl/core/quaternion_orientation_integrator.sv]
// An unused action goes straight to the output. For a nonzero product, integrate or
// rotate runs the serial multiplier 5 or 6 times and a load once, then the serial
// root and the divider for a COMPONENT_BITS-1 bit quotient; data-dependent one-bit
// normalizing shifts come between. One word at a time.
// Reset is asynchronous: orientation goes to identity, channels go empty.
`include "quaternion_orientation_integrator_assert.svh"
module quaternion_orientation_integrator import qoi_pkg::*; #(
	parameter int COMPONENT_BITS = 32
) (
	input logic        clk,
	input logic        arst_n,
	qoi_in_if.sink     in_ch,
	qoi_out_if.source  out_ch
);

	localparam int FRAC_W = COMPONENT_BITS - 2;
	localparam int QUO_W  = COMPONENT_BITS - 1;
	localparam logic [COMPONENT_BITS-1:0] ONE_Q = {2'b01, {FRAC_W{1'b0}}};
	localparam logic [QUO_W-1:0] QUO_ONE = {1'b1, {FRAC_W{1'b0}}};

	qoi_state_t state_q, state_d;
	logic       launch_q;

	logic [3:0][COMPONENT_BITS-1:0] orient_q;
	logic [3:0][COMPONENT_BITS-1:0] orient_mag;
	logic [3:0]                     osgn;
	qoi_action_t                    act_q;
	logic [2:0][31:0]               vec_q;
	logic [2:0][31:0]               vec_mag;
	logic [3:0]                     rsgn;
	logic [15:0]                    dt_q;
	logic [3:0][PROD_W-1:0]         p_q;
	logic [3:0][PROD_W-1:0]         p_mag;
	op4_t                           qa_q, rb_q, pm_q;
	logic [3:0]                     psgn_q;
	logic [3:0]                     acc_sub;
	logic [1:0]                     term_q;
	logic [PROD_W-1:0]              sum_q;
	logic                           zero_q;
	logic                           p_zero;

	logic                           out_valid_q;
	logic [3:0][COMPONENT_BITS-1:0] out_q;
	logic                           out_zero_q;

	logic in_fire, out_fire, slot_free;

	scale_ctl_t            scale_ctl;
	mag4_t                 scale_in, scale_mag;
	logic                  scale_done;
	logic                  mul_start, mul_done;
	op4_t                  mul_a, mul_b;
	prod4_t                mul_prod;
	logic                  root_start, root_done;
	logic [ROOT_W-1:0]     root_val;
	logic                  div_start, div_done;
	logic [3:0][QUO_W-1:0] div_quo;

	assign in_fire   = in_ch.valid && in_ch.ready;
	assign out_fire  = out_ch.valid && out_ch.ready;
	assign slot_free = !out_valid_q || out_ch.ready;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			osgn[i]       = orient_q[i][COMPONENT_BITS-1];
			orient_mag[i] = osgn[i] ? -orient_q[i] : orient_q[i];
			p_mag[i]      = p_q[i][PROD_W-1] ? -p_q[i] : p_q[i];
		end
		for (int i = 0; i < 3; i++)
			vec_mag[i] = vec_q[i][31] ? -vec_q[i] : vec_q[i];
		rsgn = {vec_q[2][31], vec_q[1][31], vec_q[0][31], 1'b0};
		for (int i = 0; i < 4; i++)
			acc_sub[i] = osgn[HM_A[i][term_q]] ^ rsgn[HM_B[i][term_q]] ^ HM_NEG[i][term_q];
		p_zero = (scale_mag == '0);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					case (qoi_action_t'(in_ch.action))
						ACT_HOLD:      state_d = ST_OUT;
						ACT_LOAD:      state_d = ST_PSCALE;
						ACT_INTEGRATE: state_d = ST_RMUL;
						default:       state_d = ST_QSCALE;
					endcase
				end
			end
			ST_RMUL:   if (mul_done) state_d = ST_QSCALE;
			ST_QSCALE: if (scale_done) state_d = ST_RSCALE;
			ST_RSCALE: if (scale_done) state_d = ST_MUL;
			ST_MUL:    if (mul_done) state_d = ST_ACC;
			ST_ACC:    state_d = (term_q == 2'd3) ? ST_PSCALE : ST_MUL;
			ST_PSCALE: if (scale_done) state_d = p_zero ? ST_OUT : ST_SQUARE;
			ST_SQUARE: if (mul_done) state_d = ST_SUM;
			ST_SUM:    if (term_q == 2'd3) state_d = ST_ROOT;
			ST_ROOT:   if (root_done) state_d = ST_DIV;
			ST_DIV:    if (div_done) state_d = ST_WRITE;
			ST_WRITE:  state_d = ST_OUT;
			ST_OUT:    if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs and unit operand selection
	always_comb begin
		in_ch.ready        = (state_q == ST_IDLE);
		scale_ctl.start    = launch_q && ((state_q == ST_QSCALE) || (state_q == ST_RSCALE)
			|| (state_q == ST_PSCALE));
		scale_ctl.norm_top = (state_q == ST_PSCALE);
		mul_start          = launch_q && ((state_q == ST_RMUL) || (state_q == ST_MUL)
			|| (state_q == ST_SQUARE));
		root_start         = launch_q && (state_q == ST_ROOT);
		div_start          = launch_q && (state_q == ST_DIV);
		scale_in           = '0;
		mul_a              = '0;
		mul_b              = '0;
		case (state_q)
			ST_QSCALE: begin
				for (int i = 0; i < 4; i++)
					scale_in[i] = MAG_W'(orient_mag[i]);
			end
			ST_RSCALE: begin
				if (act_q == ACT_INTEGRATE) begin
					scale_in[0] = R0_INTEG;
					for (int i = 1; i < 4; i++)
						scale_in[i] = mul_prod[i];
				end else begin
					for (int i = 1; i < 4; i++)
						scale_in[i] = MAG_W'(vec_mag[i-1]);
				end
			end
			ST_PSCALE: scale_in = p_mag;
			ST_RMUL: begin
				for (int i = 1; i < 4; i++) begin
					mul_a[i] = vec_mag[i-1];
					mul_b[i] = MUL_W'(dt_q);
				end
			end
			ST_MUL: begin
				for (int i = 0; i < 4; i++) begin
					mul_a[i] = qa_q[HM_A[i][term_q]];
					mul_b[i] = rb_q[HM_B[i][term_q]];
				end
			end
			ST_SQUARE: begin
				mul_a = pm_q;
				mul_b = pm_q;
			end
			default: begin
				scale_in = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			launch_q    <= 1'b0;
			out_valid_q <= 1'b0;
			term_q      <= '0;
			orient_q    <= {{(3*COMPONENT_BITS){1'b0}}, ONE_Q};
		end else begin
			state_q  <= state_d;
			launch_q <= (state_d != state_q);
			if (state_q == ST_OUT && slot_free)
				out_valid_q <= 1'b1;
			else if (out_fire)
				out_valid_q <= 1'b0;
			if (state_q == ST_IDLE && in_fire)
				term_q <= '0;
			else if (state_q == ST_ACC || state_q == ST_SUM)
				term_q <= term_q + 1'b1;
			if (state_q == ST_PSCALE && scale_done && p_zero)
				orient_q <= '0;
			else if (state_q == ST_WRITE) begin
				for (int i = 0; i < 4; i++)
					orient_q[i] <= psgn_q[i] ? -{1'b0, div_quo[i]} : {1'b0, div_quo[i]};
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					act_q    <= qoi_action_t'(in_ch.action);
					vec_q[0] <= in_ch.vec_x;
					vec_q[1] <= in_ch.vec_y;
					vec_q[2] <= in_ch.vec_z;
					dt_q     <= in_ch.time_step;
					zero_q   <= (orient_q == '0);
					if (qoi_action_t'(in_ch.action) == ACT_LOAD) begin
						p_q[0] <= {{32{in_ch.load_w[31]}}, in_ch.load_w};
						p_q[1] <= {{32{in_ch.vec_x[31]}}, in_ch.vec_x};
						p_q[2] <= {{32{in_ch.vec_y[31]}}, in_ch.vec_y};
						p_q[3] <= {{32{in_ch.vec_z[31]}}, in_ch.vec_z};
					end else begin
						p_q <= '0;
					end
				end
			end
			ST_QSCALE: begin
				if (scale_done)
					for (int i = 0; i < 4; i++)
						qa_q[i] <= scale_mag[i][MUL_W-1:0];
			end
			ST_RSCALE: begin
				if (scale_done)
					for (int i = 0; i < 4; i++)
						rb_q[i] <= scale_mag[i][MUL_W-1:0];
			end
			ST_ACC: begin
				for (int i = 0; i < 4; i++)
					p_q[i] <= acc_sub[i] ? p_q[i] - mul_prod[i] : p_q[i] + mul_prod[i];
			end
			ST_PSCALE: begin
				if (scale_done) begin
					zero_q <= p_zero;
					for (int i = 0; i < 4; i++) begin
						pm_q[i]   <= scale_mag[i][MUL_W-1:0];
						psgn_q[i] <= p_q[i][PROD_W-1];
					end
				end
			end
			ST_SUM: begin
				sum_q <= ((term_q == 2'd0) ? '0 : sum_q) + mul_prod[term_q];
			end
			ST_OUT: begin
				if (slot_free) begin
					out_q      <= orient_q;
					out_zero_q <= zero_q;
				end
			end
			default: begin
				sum_q <= sum_q;
			end
		endcase
	end

	qoi_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scale_ctl),
		.mag_in  (scale_in),
		.mag_out (scale_mag),
		.done    (scale_done)
	);

	qoi_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a_in   (mul_a),
		.b_in   (mul_b),
		.prod   (mul_prod),
		.done   (mul_done)
	);

	qoi_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (root_start),
		.n_in   (sum_q),
		.root   (root_val),
		.done   (root_done)
	);

	qoi_div #(.QUO_W(QUO_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a_in   (pm_q),
		.m_in   (root_val),
		.quo    (div_quo),
		.done   (div_done)
	);

	assign out_ch.valid     = out_valid_q;
	assign out_ch.out_w     = out_q[0];
	assign out_ch.out_x     = out_q[1];
	assign out_ch.out_y     = out_q[2];
	assign out_ch.out_z     = out_q[3];
	assign out_ch.zero_norm = out_zero_q;

	`QOI_ASSERT_NEXT(a_leave_idle, clk, arst_n, in_fire, state_q != ST_IDLE,
		"accepted word did not start processing")
	`QOI_ASSERT_NOW(a_root_range, clk, arst_n, (state_q == ST_ROOT) && root_done,
		root_val[ROOT_W-1:ROOT_W-2] != 2'b00, "norm below scaled range")
	`QOI_ASSERT_NOW(a_quo_range, clk, arst_n, div_done,
		(div_quo[0] <= QUO_ONE) && (div_quo[1] <= QUO_ONE) && (div_quo[2] <= QUO_ONE)
		&& (div_quo[3] <= QUO_ONE), "normalized part exceeds one")
	`QOI_ASSERT_NOW(a_zero_flag, clk, arst_n, out_valid_q && out_zero_q, out_q == '0,
		"zero flag with nonzero quaternion")

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for quaternion_orientation_integrator: a directed table, then random words.
// Needs qoi_pkg, qoi_in_if and qoi_out_if; an in-bench model predicts each result the table does not give.
module tb_top import qoi_pkg::*;;

	localparam int CB = 32;
	localparam int FB = CB - 2;
	localparam int WDOG_LIMIT = 6000;
	localparam logic signed [31:0] ONE_Q = 32'sh4000_0000;

	typedef struct {
		logic signed [CB-1:0] w, x, y, z;
		logic                 zf;
	} orient_t;

	typedef struct {
		qoi_action_t        act;
		logic signed [31:0] x, y, z, w;
		logic [15:0]        dt;
		bit                 typed;
		orient_t            res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qoi_in_if in_if();
	qoi_out_if #(.COMPONENT_BITS(CB)) out_if();

	quaternion_orientation_integrator #(.COMPONENT_BITS(CB)) dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	longint  orient_st[4];
	orient_t pending_q[$];
	int      errors = 0;
	int      idle_cycles = 0;
	bit      quiet = 1'b0;
	int      out_wait = 0;

	function automatic longint unsigned mag(longint a);
		return a < 0 ? longint'(0) - a : a;
	endfunction

	// same shift on all four parts, largest magnitude into [2^(top-1), 2^top)
	function automatic void scale_block(inout longint v[4], input int top);
		longint unsigned mg[4];
		longint unsigned mx;
		longint unsigned m;
		int down, up;
		mx = 0;
		down = 0;
		up = 0;
		for (int i = 0; i < 4; i++) begin
			mg[i] = mag(v[i]);
			if (mg[i] > mx) mx = mg[i];
		end
		if (mx == 0) return;
		while ((mx >> down) >= (64'd1 << top)) down++;
		while ((mx << up) < (64'd1 << (top - 1))) up++;
		for (int i = 0; i < 4; i++) begin
			m = (mg[i] >> down) << up;
			v[i] = v[i] < 0 ? -longint'(m) : longint'(m);
		end
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// floor(a * 2^FB / m), a <= m
	function automatic longint unsigned ratio_fixed(longint unsigned a, longint unsigned m);
		longint unsigned qt, r;
		qt = 0;
		r = a;
		if (r >= m) begin
			qt = 1;
			r -= m;
		end
		for (int i = 0; i < FB; i++) begin
			r <<= 1;
			qt <<= 1;
			if (r >= m) begin
				r -= m;
				qt |= 1;
			end
		end
		return qt;
	endfunction

	function automatic orient_t advance_orient(qoi_action_t act, logic signed [31:0] vx,
			logic signed [31:0] vy, logic signed [31:0] vz, logic signed [31:0] lw,
			logic [15:0] dt);
		longint q[4], r[4], p[4];
		longint unsigned sum, m, f;
		logic zf;
		orient_t res;
		for (int i = 0; i < 4; i++) q[i] = orient_st[i];
		if (act == ACT_HOLD) begin
			zf = (q[0] | q[1] | q[2] | q[3]) == 0;
		end else begin
			if (act == ACT_LOAD) begin
				p[0] = lw; p[1] = vx; p[2] = vy; p[3] = vz;
			end else begin
				if (act == ACT_INTEGRATE) begin
					r[0] = longint'(64'd1 << 33);
					r[1] = longint'(vx) * longint'(dt);
					r[2] = longint'(vy) * longint'(dt);
					r[3] = longint'(vz) * longint'(dt);
				end else begin
					r[0] = 0; r[1] = vx; r[2] = vy; r[3] = vz;
				end
				scale_block(q, 30);
				scale_block(r, 30);
				p[0] = q[0]*r[0] - q[1]*r[1] - q[2]*r[2] - q[3]*r[3];
				p[1] = q[0]*r[1] + q[1]*r[0] + q[2]*r[3] - q[3]*r[2];
				p[2] = q[0]*r[2] + q[2]*r[0] + q[3]*r[1] - q[1]*r[3];
				p[3] = q[0]*r[3] + q[3]*r[0] + q[1]*r[2] - q[2]*r[1];
			end
			zf = (p[0] | p[1] | p[2] | p[3]) == 0;
			if (zf) begin
				for (int i = 0; i < 4; i++) q[i] = 0;
			end else begin
				scale_block(p, 31);
				sum = 0;
				for (int i = 0; i < 4; i++) sum += mag(p[i]) * mag(p[i]);
				m = int_sqrt(sum);
				for (int i = 0; i < 4; i++) begin
					f = ratio_fixed(mag(p[i]), m);
					q[i] = p[i] < 0 ? -longint'(f) : longint'(f);
				end
			end
			for (int i = 0; i < 4; i++) orient_st[i] = longint'($signed(q[i][CB-1:0]));
		end
		res.w = orient_st[0][CB-1:0];
		res.x = orient_st[1][CB-1:0];
		res.y = orient_st[2][CB-1:0];
		res.z = orient_st[3][CB-1:0];
		res.zf = zf;
		return res;
	endfunction

	function automatic orient_t mk_res(logic signed [31:0] w, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic zf);
		orient_t r;
		r.w = w; r.x = x; r.y = y; r.z = z; r.zf = zf;
		return r;
	endfunction

	function automatic logic signed [31:0] rand_val();
		logic signed [31:0] v;
		v = $urandom;
		return v >>> $urandom_range(0, 31);
	endfunction

	// drive one word from a falling edge, hold until accepted
	task automatic send_word(stim_row_t row);
		orient_t res;
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_if.action = row.act;
		in_if.vec_x = row.x;
		in_if.vec_y = row.y;
		in_if.vec_z = row.z;
		in_if.load_w = row.w;
		in_if.time_step = row.dt;
		in_if.valid = 1'b1;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
		res = advance_orient(row.act, row.x, row.y, row.z, row.w, row.dt);
		pending_q.push_back(row.typed ? row.res : res);
		@(negedge clk);
	endtask

	// result side: random stalls, compare in order
	always @(negedge clk) begin
		if (out_wait > 0 && !quiet) begin
			out_if.ready = 1'b0;
			out_wait--;
		end else begin
			out_if.ready = 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_if.valid && out_if.ready) begin
			orient_t e;
			out_wait = $urandom_range(0, 14);
			if (pending_q.size() == 0) begin
				$display("%0t: unexpected word w=%h x=%h y=%h z=%h zf=%b", $time,
					out_if.out_w, out_if.out_x, out_if.out_y, out_if.out_z, out_if.zero_norm);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (out_if.out_w !== e.w || out_if.out_x !== e.x || out_if.out_y !== e.y ||
						out_if.out_z !== e.z || out_if.zero_norm !== e.zf) begin
					$display("%0t: mismatch exp w=%h x=%h y=%h z=%h zf=%b", $time,
						e.w, e.x, e.y, e.z, e.zf);
					$display("%0t:          got w=%h x=%h y=%h z=%h zf=%b", $time,
						out_if.out_w, out_if.out_x, out_if.out_y, out_if.out_z,
						out_if.zero_norm);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	stim_row_t table_rows[$];
	orient_t   zero_res;

	function automatic stim_row_t row(qoi_action_t act, logic signed [31:0] x,
			logic signed [31:0] y, logic signed [31:0] z, logic signed [31:0] w,
			logic [15:0] dt, bit typed, orient_t res);
		stim_row_t r;
		r.act = act; r.x = x; r.y = y; r.z = z; r.w = w; r.dt = dt;
		r.typed = typed; r.res = res;
		return r;
	endfunction

	initial begin
		stim_row_t r;
		int sel;
		in_if.valid = 1'b0;
		in_if.action = ACT_HOLD;
		in_if.vec_x = '0;
		in_if.vec_y = '0;
		in_if.vec_z = '0;
		in_if.load_w = '0;
		in_if.time_step = '0;
		out_if.ready = 1'b0;
		orient_st[0] = longint'(1) << FB;
		orient_st[1] = 0;
		orient_st[2] = 0;
		orient_st[3] = 0;
		zero_res = mk_res(0, 0, 0, 0, 1'b1);

		table_rows.push_back(row(ACT_HOLD, 0, 0, 0, 0, 0, 1, mk_res(ONE_Q, 0, 0, 0, 0)));
		table_rows.push_back(row(ACT_INTEGRATE, 32'sh7fff_ffff, 32'sh8000_0000, 5, 0, 0,
			1, mk_res(ONE_Q, 0, 0, 0, 0)));
		table_rows.push_back(row(ACT_INTEGRATE, 32'sh7fff_ffff, 0, 0, 0, 16'hffff, 0, zero_res));
		table_rows.push_back(row(ACT_ROTATE, 32'sh0001_0000, 0, 0, 0, 0, 0, zero_res));
		table_rows.push_back(row(ACT_ROTATE, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
			0, 0, 0, zero_res));
		table_rows.push_back(row(ACT_LOAD, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
			32'sh7fff_ffff, 16'hffff, 0, zero_res));
		table_rows.push_back(row(ACT_LOAD, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 0, 1, mk_res(32'shE000_0000, 32'shE000_0000, 32'shE000_0000,
			32'shE000_0000, 0)));
		table_rows.push_back(row(ACT_LOAD, 0, 0, 0, 0, 0, 1, zero_res));
		table_rows.push_back(row(ACT_HOLD, 0, 0, 0, 0, 0, 1, zero_res));
		table_rows.push_back(row(ACT_INTEGRATE, 32'sh0003_0000, 1, 2, 0, 16'h1234, 1, zero_res));
		table_rows.push_back(row(ACT_ROTATE, 32'sh0001_0000, 0, 0, 0, 0, 1, zero_res));
		table_rows.push_back(row(ACT_LOAD, 0, 0, 0, ONE_Q, 0, 1, mk_res(ONE_Q, 0, 0, 0, 0)));
		table_rows.push_back(row(ACT_ROTATE, 0, 0, 0, 32'sh7fff_ffff, 0, 1, zero_res));
		table_rows.push_back(row(ACT_LOAD, 1, 0, 0, 0, 0, 1, mk_res(0, ONE_Q, 0, 0, 0)));
		table_rows.push_back(row(ACT_INTEGRATE, 0, 32'sh8000_0000, 0, 0, 16'h0001, 0, zero_res));
		table_rows.push_back(row(ACT_INTEGRATE, 32'sh0000_8000, -32'sh0002_0000,
			32'sh0001_8000, 0, 16'h8000, 0, zero_res));
		table_rows.push_back(row(ACT_ROTATE, -1, 2, -3, 0, 0, 0, zero_res));
		table_rows.push_back(row(ACT_HOLD, 32'sh5555_5555, 32'shaaaa_aaaa, 0, 0, 16'haaaa,
			0, zero_res));
		table_rows.push_back(row(ACT_LOAD, 32'sh1234_5678, -32'sh0765_4321, 7, -1, 0, 0,
			zero_res));
		table_rows.push_back(row(ACT_INTEGRATE, 32'sh0010_0000, 32'sh0020_0000,
			-32'sh0030_0000, 0, 16'h0100, 0, zero_res));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (table_rows[i]) send_word(table_rows[i]);

		for (int n = 0; n < 1150; n++) begin
			if (n % 97 == 0) quiet = ($urandom_range(0, 3) == 0);
			sel = $urandom_range(0, 99);
			r = row(ACT_INTEGRATE, rand_val(), rand_val(), rand_val(), $urandom,
				16'($urandom), 0, zero_res);
			if (sel < 45) begin
				r.act = ACT_INTEGRATE;
				if ($urandom_range(0, 9) == 0) r.dt = 0;
			end else if (sel < 75) begin
				r.act = ACT_ROTATE;
			end else if (sel < 92) begin
				r.act = ACT_LOAD;
				r.w = rand_val();
				if ($urandom_range(0, 9) == 0) begin
					r.x = 0; r.y = 0; r.z = 0; r.w = 0;
				end
			end else begin
				r.act = ACT_HOLD;
			end
			// now and then an all-zero vector, which zeroes a rotated state
			if (r.act != ACT_LOAD && $urandom_range(0, 40) == 0) begin
				r.x = 0; r.y = 0; r.z = 0;
			end
			send_word(r);
		end
		in_if.valid = 1'b0;
		quiet = 1'b0;

		while (pending_q.size() != 0) @(posedge clk);
		repeat (500) @(posedge clk);
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/qoi_pkg.sv
rtl/core/qoi_if.sv
rtl/core/qoi_scale.sv
rtl/core/qoi_mul.sv
rtl/core/qoi_root.sv
rtl/core/qoi_div.sv
rtl/core/quaternion_orientation_integrator.sv
test/tb_top.sv
